// ===== rtl/ternary_weight_dot_product_scaled_macros.svh =====
// Assertion macros for the ternary weight dot product block.
// No dependencies; included by the top level only.
`ifndef TERNARY_WEIGHT_DOT_PRODUCT_SCALED_MACROS_SVH
`define TERNARY_WEIGHT_DOT_PRODUCT_SCALED_MACROS_SVH

// same-cycle implication, disabled while in reset
`define TWDPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define TWDPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/twdps_pkg.sv =====
// Package for the ternary weight dot product block: widths, weight codes,
// input word type and the per-lane term function. No dependencies.
`timescale 1ns / 1ps

package twdps_pkg;

    localparam int LANES    = 4;
    localparam int ACT_W    = 16;
    localparam int TERM_W   = ACT_W + 1;   // holds the negated minimum
    localparam int LSUM_W   = TERM_W + 2;  // sum of four terms
    localparam int ACC_W    = 32;
    localparam int GAIN_W   = 32;
    localparam int CNT_W    = 3;
    localparam int WCODE_W  = 2;

    localparam logic [WCODE_W-1:0] W_POS = 2'b01;
    localparam logic [WCODE_W-1:0] W_NEG = 2'b10;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [LANES*WCODE_W-1:0]     weight_byte;
        logic [LANES-1:0][ACT_W-1:0]  act;
        logic [CNT_W-1:0]             valid_lanes;
        logic                         last;
    } t_item;

    // finished dot product handed to the scaling stage
    typedef struct packed {
        logic             valid;
        logic [ACC_W-1:0] sum;
    } t_fin;

    // codes 00 and 11 both mean weight zero
    function automatic logic signed [TERM_W-1:0] lane_term(
        input logic [WCODE_W-1:0] code,
        input logic [ACT_W-1:0]   act
    );
        logic signed [TERM_W-1:0] ext;
        begin
            ext = $signed({act[ACT_W-1], act});
            case (code)
                W_POS:   lane_term = ext;
                W_NEG:   lane_term = -ext;
                default: lane_term = '0;
            endcase
        end
    endfunction

endpackage

// ===== rtl/twdps_lane_sum.sv =====
// Four-lane ternary sum of one input word, sign-extended to accumulator width.
// Depends on twdps_pkg.
`timescale 1ns / 1ps

module twdps_lane_sum (
    input  twdps_pkg::t_item            i_item,
    output logic [twdps_pkg::ACC_W-1:0] o_sum
);
    import twdps_pkg::*;

    logic signed [TERM_W-1:0] w_term [LANES];
    logic signed [LSUM_W-1:0] w_total;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        // lane takes part when its index is below the count; 5..7 act as 4
        always_comb begin
            if (CNT_W'(g) < i_item.valid_lanes) begin
                w_term[g] = lane_term(i_item.weight_byte[g*WCODE_W +: WCODE_W],
                                      i_item.act[g]);
            end else begin
                w_term[g] = '0;
            end
        end
    end

    always_comb begin
        w_total = '0;
        for (int k = 0; k < LANES; k++) begin
            w_total = w_total + LSUM_W'(w_term[k]);
        end
    end

    assign o_sum = ACC_W'(w_total);

endmodule

// ===== rtl/twdps_scale.sv =====
// Q31 gain multiply and output register: bits 62..31 of sum * gain.
// Depends on twdps_pkg.
`timescale 1ns / 1ps

module twdps_scale (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  twdps_pkg::t_fin              i_fin,
    input  logic [twdps_pkg::GAIN_W-1:0] i_gain,
    input  logic                         i_out_stall,
    output logic                         o_free,
    output logic                         o_out_valid,
    output logic [twdps_pkg::ACC_W-1:0]  o_scaled_sum
);
    import twdps_pkg::*;

    localparam int PROD_W = ACC_W + GAIN_W;

    logic                     r_valid;
    logic [ACC_W-1:0]         r_sum;
    logic                     n_valid;
    logic signed [PROD_W-1:0] w_prod;

    assign o_free = !r_valid || !i_out_stall;
    assign w_prod = PROD_W'($signed(i_fin.sum)) * PROD_W'($signed(i_gain));

    always_comb begin
        if (o_free) begin
            n_valid = i_fin.valid;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // truncating shift by 31, no saturation
    always_ff @(posedge i_clk) begin
        if (o_free && i_fin.valid) begin
            r_sum <= w_prod[PROD_W-2 -: ACC_W];
        end
    end

    assign o_out_valid  = r_valid;
    assign o_scaled_sum = r_sum;

endmodule

// ===== rtl/ternary_weight_dot_product_scaled.sv =====
// Top level of the ternary weight dot product with Q31 output gain.
// Depends on twdps_pkg, twdps_lane_sum, twdps_scale and the macros header.
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+-----------------------------------
//  in      | input     | i_in_valid / o_in_stall    | weight byte, act 0..3, lanes, last
//  out     | output    | o_out_valid / i_out_stall  | scaled_sum
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | gain_q31
//
// One word per cycle sustained, but a last word waits while the hold register
// is full and blocked. A word is registered; a non-last word is summed into
// the accumulator on the next edge, a last word's total goes to the hold
// register, then through the 32x32 multiplier into the output register. Reset
// (synchronous) clears the sum and sets the gain to just under one. Output stall
// backs up through the hold register; non-last words keep flowing while a result waits.
`timescale 1ns / 1ps

`include "ternary_weight_dot_product_scaled_macros.svh"

module ternary_weight_dot_product_scaled (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_weight_byte,
    input  logic signed [15:0]            i_act_0,
    input  logic signed [15:0]            i_act_1,
    input  logic signed [15:0]            i_act_2,
    input  logic signed [15:0]            i_act_3,
    input  logic [2:0]                    i_valid_lanes,
    input  logic                          i_last,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [31:0]            o_scaled_sum,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic signed [31:0]            i_cfg_data
);
    import twdps_pkg::*;

    t_item             r_in;
    logic              r_in_valid;
    logic              n_in_valid;
    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  n_acc;
    t_fin              r_fin;
    t_fin              n_fin;
    logic [GAIN_W-1:0] r_gain;

    logic              w_in_accept;
    logic              w_step;
    logic              w_fin_free;
    logic              w_out_free;
    logic [ACC_W-1:0]  w_lane_sum;
    logic [ACC_W-1:0]  w_new_sum;
    logic [ACC_W-1:0]  w_scaled;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_gain <= i_cfg_data;
        end
    end

    twdps_lane_sum u_lane_sum (
        .i_item (r_in),
        .o_sum  (w_lane_sum)
    );

    twdps_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fin        (r_fin),
        .i_gain       (r_gain),
        .i_out_stall  (i_out_stall),
        .o_free       (w_out_free),
        .o_out_valid  (o_out_valid),
        .o_scaled_sum (w_scaled)
    );

    assign o_scaled_sum = w_scaled;

    always_comb begin
        w_fin_free  = !r_fin.valid || w_out_free;
        // only a last word needs room downstream
        w_step      = r_in_valid && (!r_in.last || w_fin_free);
        o_in_stall  = r_in_valid && !w_step;
        w_in_accept = i_in_valid && !o_in_stall;
        w_new_sum   = r_acc + w_lane_sum;

        n_in_valid = r_in_valid;
        if (w_in_accept) begin
            n_in_valid = 1'b1;
        end else if (w_step) begin
            n_in_valid = 1'b0;
        end

        n_acc = r_acc;
        if (w_step) begin
            n_acc = r_in.last ? '0 : w_new_sum;
        end

        n_fin = r_fin;
        if (w_step && r_in.last) begin
            n_fin.valid = 1'b1;
            n_fin.sum   = w_new_sum;
        end else if (w_out_free) begin
            n_fin.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_acc       <= '0;
            r_fin.valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_acc       <= n_acc;
            r_fin       <= n_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in.weight_byte <= i_weight_byte;
            r_in.act[0]      <= i_act_0;
            r_in.act[1]      <= i_act_1;
            r_in.act[2]      <= i_act_2;
            r_in.act[3]      <= i_act_3;
            r_in.valid_lanes <= i_valid_lanes;
            r_in.last        <= i_last;
        end
    end

    `TWDPS_ASSERT_NEXT(a_acc_cleared, i_clk, i_rst_n, w_step && r_in.last, r_acc == '0,
        "accumulator not cleared after last word")
    `TWDPS_ASSERT_NEXT(a_acc_adds, i_clk, i_rst_n, w_step && !r_in.last,
        r_acc == $past(w_new_sum), "accumulator missed a word")
    `TWDPS_ASSERT_NEXT(a_fin_held, i_clk, i_rst_n, r_fin.valid && !w_out_free,
        r_fin.valid && r_fin.sum == $past(r_fin.sum), "finished sum lost while blocked")
    `TWDPS_ASSERT_SAME(a_out_source, i_clk, i_rst_n, $rose(o_out_valid), $past(r_fin.valid),
        "result without a finished sum")

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the ternary weight dot product with Q31 gain.
// Depends on twdps_pkg and the ternary_weight_dot_product_scaled top level.
// Directed table first, then random vectors in three idle/stall phases.
`timescale 1ns / 1ps

module tb;
    import twdps_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS    = 450;
    localparam int SETTLE_CYCLES  = 6;

    typedef enum logic {ROW_WORD, ROW_GAIN} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [31:0] gain;
        t_item       item;
        bit          typed;
        logic [31:0] result;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [7:0]         i_weight_byte;
    logic signed [15:0] i_act_0;
    logic signed [15:0] i_act_1;
    logic signed [15:0] i_act_2;
    logic signed [15:0] i_act_3;
    logic [2:0]         i_valid_lanes;
    logic               i_last;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [31:0] o_scaled_sum;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic signed [31:0] i_cfg_data;

    ternary_weight_dot_product_scaled uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_weight_byte (i_weight_byte),
        .i_act_0       (i_act_0),
        .i_act_1       (i_act_1),
        .i_act_2       (i_act_2),
        .i_act_3       (i_act_3),
        .i_valid_lanes (i_valid_lanes),
        .i_last        (i_last),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_scaled_sum  (o_scaled_sum),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // model state
    logic [31:0] acc_model;
    logic [31:0] gain_model;
    logic [31:0] scaled_sum_q[$];

    bit          cur_typed;
    logic [31:0] cur_typed_val;
    int          idle_pct;
    int          stall_pct;
    int          fail_cnt;
    int          quiet_cycles;
    t_row        dir_rows[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // signed sum of the lanes that take part; codes 00 and 11 add nothing
    function automatic logic [31:0] ternary_delta(logic [7:0] w,
                                                  logic [LANES-1:0][ACT_W-1:0] acts,
                                                  logic [2:0] n);
        logic [31:0] s;
        s = '0;
        for (int i = 0; i < LANES; i++) begin
            if (i < n) begin
                case (w[2*i +: 2])
                    W_POS:   s = s + {{16{acts[i][15]}}, acts[i]};
                    W_NEG:   s = s - {{16{acts[i][15]}}, acts[i]};
                    default: ;
                endcase
            end
        end
        return s;
    endfunction

    // bits 62..31 of the full product, no rounding or saturation
    function automatic logic [31:0] q31_scale(logic [31:0] sum, logic [31:0] g);
        logic signed [63:0] p;
        p = 64'($signed(sum)) * 64'($signed(g));
        return p[62:31];
    endfunction

    function automatic t_row mk_word(logic [7:0] w, logic [15:0] a0, logic [15:0] a1,
                                     logic [15:0] a2, logic [15:0] a3, logic [2:0] n,
                                     logic lst, bit typed, logic [31:0] res);
        t_row r;
        r.kind             = ROW_WORD;
        r.gain             = '0;
        r.item.weight_byte = w;
        r.item.act         = {a3, a2, a1, a0};
        r.item.valid_lanes = n;
        r.item.last        = lst;
        r.typed            = typed;
        r.result           = res;
        return r;
    endfunction

    function automatic t_row mk_gain(logic [31:0] g);
        t_row r;
        r        = mk_word('0, '0, '0, '0, '0, '0, 1'b0, 1'b0, '0);
        r.kind   = ROW_GAIN;
        r.gain   = g;
        return r;
    endfunction

    function automatic logic [15:0] rand_act();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_word(t_item it, bit typed, logic [31:0] res);
        @(negedge i_clk);
        // idle cycle by cycle
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_weight_byte = it.weight_byte;
        i_act_0       = it.act[0];
        i_act_1       = it.act[1];
        i_act_2       = it.act[2];
        i_act_3       = it.act[3];
        i_valid_lanes = it.valid_lanes;
        i_last        = it.last;
        cur_typed     = typed;
        cur_typed_val = res;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // wait until every pending result is back, then let in-flight words settle
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        @(posedge i_clk);
        while (scaled_sum_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_gain(logic [31:0] g);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = g;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic run_random(int words);
        t_item it;
        int    len;
        int    sent;
        sent = 0;
        while (sent < words) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
                it.weight_byte = 8'($urandom);
                it.act         = {rand_act(), rand_act(), rand_act(), rand_act()};
                it.last        = (k == len - 1);
                it.valid_lanes = it.last ? 3'($urandom_range(1, 4)) : 3'd4;
                // odd lane counts, including 0 and 5..7
                if ($urandom_range(9) == 0) it.valid_lanes = 3'($urandom_range(0, 7));
                send_word(it, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // receiver side
    always @(negedge i_clk) begin
        i_out_stall = ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            acc_model  = '0;
            gain_model = GAIN_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready) gain_model = i_cfg_data;
            if (i_in_valid && !o_in_stall) begin
                acc_model = acc_model + ternary_delta(i_weight_byte,
                                                      {i_act_3, i_act_2, i_act_1, i_act_0},
                                                      i_valid_lanes);
                if (i_last) begin
                    scaled_sum_q.push_back(cur_typed ? cur_typed_val
                                                     : q31_scale(acc_model, gain_model));
                    acc_model = '0;
                end
            end
            if (o_out_valid && !i_out_stall) begin
                if (scaled_sum_q.size() == 0) begin
                    $error("scaled_sum: unexpected word %0d", o_scaled_sum);
                    fail_cnt++;
                end else begin
                    want = scaled_sum_q.pop_front();
                    if (o_scaled_sum !== want) begin
                        $error("scaled_sum: expected %0d, got %0d",
                               $signed(want), o_scaled_sum);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no traffic on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_weight_byte = '0;
        i_act_0       = '0;
        i_act_1       = '0;
        i_act_2       = '0;
        i_act_3       = '0;
        i_valid_lanes = '0;
        i_last        = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        cur_typed     = 1'b0;
        cur_typed_val = '0;
        idle_pct      = 11;
        stall_pct     = 55;

        // gain starts at reset value
        dir_rows.push_back(mk_word(8'h00, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 3'd4,
                                   1'b1, 1'b1, '0));
        dir_rows.push_back(mk_word(8'h55, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 3'd4,
                                   1'b0, 1'b0, '0));
        dir_rows.push_back(mk_word(8'hAA, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 3'd4,
                                   1'b1, 1'b0, '0));
        // code 11 is a zero weight
        dir_rows.push_back(mk_word(8'hFF, 16'h8000, 16'h7FFF, 16'h1234, 16'hABCD, 3'd4,
                                   1'b1, 1'b1, '0));
        dir_rows.push_back(mk_word(8'h55, 16'h03E8, 16'h03E8, 16'h03E8, 16'h03E8, 3'd0,
                                   1'b1, 1'b1, '0));
        dir_rows.push_back(mk_word(8'h55, 16'h0064, 16'h00C8, 16'h012C, 16'h0190, 3'd5,
                                   1'b0, 1'b0, '0));
        dir_rows.push_back(mk_word(8'h99, 16'h0064, 16'h00C8, 16'h012C, 16'h0190, 3'd6,
                                   1'b0, 1'b0, '0));
        dir_rows.push_back(mk_word(8'h66, 16'h0064, 16'h00C8, 16'h012C, 16'h0190, 3'd7,
                                   1'b1, 1'b0, '0));
        dir_rows.push_back(mk_word(8'h55, 16'h0001, 16'h0002, 16'h0004, 16'h0008, 3'd1,
                                   1'b0, 1'b0, '0));
        dir_rows.push_back(mk_word(8'hA5, 16'h0001, 16'h0002, 16'h0004, 16'h0008, 3'd2,
                                   1'b0, 1'b0, '0));
        dir_rows.push_back(mk_word(8'h5A, 16'h0001, 16'h0002, 16'h0004, 16'h0008, 3'd3,
                                   1'b1, 1'b0, '0));
        dir_rows.push_back(mk_gain(32'h0000_0000));
        dir_rows.push_back(mk_word(8'h55, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 3'd4,
                                   1'b1, 1'b1, '0));
        dir_rows.push_back(mk_gain(32'h0000_0001));
        dir_rows.push_back(mk_word(8'hAA, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 3'd4,
                                   1'b1, 1'b0, '0));
        dir_rows.push_back(mk_gain(32'hFFFF_FFFF));
        dir_rows.push_back(mk_word(8'h55, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 3'd4,
                                   1'b1, 1'b0, '0));
        dir_rows.push_back(mk_gain(32'h8000_0000));
        // minus one times -131072
        dir_rows.push_back(mk_word(8'h55, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 3'd4,
                                   1'b1, 1'b1, 32'h0002_0000));
        dir_rows.push_back(mk_word(8'hA6, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0001, 3'd4,
                                   1'b1, 1'b0, '0));

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_GAIN) begin
                drain();
                write_gain(dir_rows[r].gain);
            end else begin
                send_word(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].result);
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            drain();
            idle_pct  = (ph == 0) ? 11 : (ph == 1) ? 55 : 0;
            stall_pct = (ph == 0) ? 55 : (ph == 1) ? 11 : 0;
            write_gain((ph == 1) ? 32'h4000_0000 : 32'($urandom));
            run_random(PHASE_WORDS);
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (fail_cnt == 0 && scaled_sum_q.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/twdps_pkg.sv
rtl/twdps_lane_sum.sv
rtl/twdps_scale.sv
rtl/ternary_weight_dot_product_scaled.sv
tb/sv/tb.sv
